### rtl/core/leb_pkg.sv
// leb_pkg: shared types and constants for the line edit buffer
// no dependencies; imported by leb_decode and line_edit_buffer
`default_nettype none

package leb_pkg;

	localparam int unsigned CHAR_W        = 8;
	localparam int unsigned CFG_IDX_W     = 3;
	localparam int unsigned LINE_DEPTH_DF = 64;

	localparam logic [CHAR_W-1:0] NL_CODE    = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CODE = 8'd32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ERASE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KILL_LINE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRINT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KILL_WORD = 3'd4;

	// register reset values
	localparam logic [CHAR_W-1:0] ERASE_RST     = 8'd35;
	localparam logic [CHAR_W-1:0] KILL_LINE_RST = 8'd92;
	localparam logic [CHAR_W-1:0] PRINT_RST     = 8'd42;
	localparam logic [CHAR_W-1:0] END_RST       = 8'd126;
	localparam logic [CHAR_W-1:0] KILL_WORD_RST = 8'd36;

	typedef logic [2:0] cmd_t;

	localparam cmd_t CMD_PLAIN     = 3'd0;
	localparam cmd_t CMD_END       = 3'd1;
	localparam cmd_t CMD_ERASE     = 3'd2;
	localparam cmd_t CMD_KILL_LINE = 3'd3;
	localparam cmd_t CMD_PRINT     = 3'd4;
	localparam cmd_t CMD_KILL_WORD = 3'd5;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              has_char;
		logic              eol;
	} item_t;

endpackage

`default_nettype wire

### rtl/core/line_edit_buffer.sv
// line_edit_buffer: top level, line store in leb_ram, edit sequencer, output queue
// depends on leb_pkg, leb_ram, leb_decode
//
// channel   direction  signals                                 transfer
// in        request    in_valid, in_ready, in_char             valid & ready
// out       result     out_valid, out_ready, out_char,         valid & ready
//                      has_char, end_of_line
// cfg       write      cfg_we, cfg_index, cfg_data             cfg_we
//
// ordinary, erase and kill-line requests are accepted once the output queue has room
// print/end/full-store flush: reads each stored character in turn, paced by the
// single ram read port and the two-entry output queue; out_ready low stalls the walk
// kill-word: walks back from the last stored character, each ram read registered before the space check
// reset clears the fill count and queue; store contents stay undefined until written
`default_nettype none

module line_edit_buffer #(
	parameter int unsigned LINE_DEPTH = leb_pkg::LINE_DEPTH_DF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [leb_pkg::CHAR_W-1:0]    in_char,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [leb_pkg::CHAR_W-1:0]    out_char,
	output logic                               has_char,
	output logic                               end_of_line,
	input  wire logic                          cfg_we,
	input  wire logic [leb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [leb_pkg::CHAR_W-1:0]    cfg_data
);

	import leb_pkg::*;

	localparam int unsigned CNT_W = $clog2(LINE_DEPTH + 1);
	localparam int unsigned IDX_W = $clog2(LINE_DEPTH);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(LINE_DEPTH);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FLUSH = 2'd1;
	localparam logic [1:0] ST_WORD  = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic              pend_q;
	logic [CHAR_W-1:0] pend_char_q;

	logic              rd_v_s1;
	logic              rd_eol_s1;
	logic              wk_v_s1;

	item_t             head_q;
	item_t             skid_q;
	logic              head_v_q;
	logic              skid_v_q;

	cmd_t              cmd;
	logic [CHAR_W-1:0] ch;
	logic [CHAR_W-1:0] rdata;

	logic              accept;
	logic              pop;
	logic [1:0]        occ;
	logic              can_issue;
	logic [CNT_W-1:0]  cnt_dec;
	logic              last_rd;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [CHAR_W-1:0] ram_wdata;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;

	logic              push;
	item_t             push_item;

	leb_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_char   (in_char),
		.cmd       (cmd),
		.ch        (ch)
	);

	leb_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (LINE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	assign pop       = head_v_q && out_ready;
	assign occ       = {1'b0, head_v_q} + {1'b0, skid_v_q} + {1'b0, rd_v_s1};
	assign can_issue = occ <= (2'd1 + {1'b0, pop});
	assign cnt_dec   = cnt_q - 1'b1;
	assign last_rd   = (rd_idx_q == cnt_dec[IDX_W-1:0]);

	assign in_ready = (state_q == ST_IDLE) && !rd_v_s1 && can_issue;
	assign accept   = in_valid && in_ready;

	// store access and output queue push
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[IDX_W-1:0];
		ram_wdata = ch;
		ram_re    = 1'b0;
		ram_raddr = rd_idx_q;
		push      = rd_v_s1;
		push_item = '{ch: rdata, has_char: 1'b1, eol: rd_eol_s1};
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_PLAIN && cnt_q != FULL) begin
					ram_we = 1'b1;
				end
				if (accept && cmd == CMD_PRINT && cnt_q == '0) begin
					push      = 1'b1;
					push_item = '{ch: '0, has_char: 1'b0, eol: 1'b1};
				end
			end
			ST_FLUSH: begin
				ram_re = can_issue;
				if (can_issue && last_rd && pend_q) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = pend_char_q;
				end
			end
			ST_WORD: begin
				ram_raddr = cnt_dec[IDX_W-1:0];
				ram_re    = (cnt_q != '0) && !(wk_v_s1 && rdata == SPACE_CODE);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			rd_idx_q <= '0;
			pend_q   <= 1'b0;
			rd_v_s1  <= 1'b0;
			wk_v_s1  <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_FLUSH) && can_issue;
			wk_v_s1 <= (state_q == ST_WORD) && ram_re;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd)
							CMD_END, CMD_PRINT: begin
								if (cnt_q != '0) begin
									state_q  <= ST_FLUSH;
									rd_idx_q <= '0;
									pend_q   <= 1'b0;
								end
							end
							CMD_ERASE: begin
								if (cnt_q != '0) begin
									cnt_q <= cnt_dec;
								end
							end
							CMD_KILL_LINE: cnt_q <= '0;
							CMD_KILL_WORD: begin
								if (cnt_q != '0) begin
									state_q <= ST_WORD;
								end
							end
							CMD_PLAIN: begin
								if (cnt_q == FULL) begin
									state_q  <= ST_FLUSH;
									rd_idx_q <= '0;
									pend_q   <= 1'b1;
								end else begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				ST_FLUSH: begin
					if (can_issue) begin
						if (last_rd) begin
							state_q <= ST_IDLE;
							cnt_q   <= {{(CNT_W-1){1'b0}}, pend_q};
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
				end
				ST_WORD: begin
					if (ram_re) begin
						cnt_q <= cnt_dec;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_char_q <= ch;
		end
		rd_eol_s1 <= last_rd;
	end

	// two-entry output queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (pop && skid_v_q) begin
				skid_v_q <= push;
			end else if (!head_v_q || pop) begin
				head_v_q <= push;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_v_q) begin
			head_q <= skid_q;
			skid_q <= push_item;
		end else if (!head_v_q || pop) begin
			head_q <= push_item;
		end else if (push) begin
			skid_q <= push_item;
		end
	end

	assign out_valid   = head_v_q;
	assign out_char    = head_q.ch;
	assign has_char    = head_q.has_char;
	assign end_of_line = head_q.eol;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL)
		else $error("fill count beyond store depth");

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> head_v_q)
		else $error("skid entry without head entry");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(head_v_q && skid_v_q && !out_ready) |-> !push)
		else $error("output queue overflow");

	a_one_read: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_v_s1 && wk_v_s1))
		else $error("flush and word reads in flight together");

	a_flush_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && can_issue && last_rd) |=> (state_q == ST_IDLE && rd_v_s1))
		else $error("flush did not end after last read");

endmodule

`default_nettype wire

### rtl/core/leb_ram.sv
// leb_ram: generic single write, single read synchronous ram
// registered read data; no package dependency
`default_nettype none

module leb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/leb_decode.sv
// leb_decode: control character registers and character classification
// depends on leb_pkg
`default_nettype none

module leb_decode (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [leb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [leb_pkg::CHAR_W-1:0]        cfg_data,
	input  wire logic [leb_pkg::CHAR_W-1:0]        in_char,
	output leb_pkg::cmd_t                          cmd,
	output logic      [leb_pkg::CHAR_W-1:0]        ch
);

	import leb_pkg::*;

	logic [CHAR_W-1:0] erase_q;
	logic [CHAR_W-1:0] kill_line_q;
	logic [CHAR_W-1:0] print_q;
	logic [CHAR_W-1:0] end_q;
	logic [CHAR_W-1:0] kill_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_q     <= ERASE_RST;
			kill_line_q <= KILL_LINE_RST;
			print_q     <= PRINT_RST;
			end_q       <= END_RST;
			kill_word_q <= KILL_WORD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ERASE:     erase_q     <= cfg_data;
				REG_KILL_LINE: kill_line_q <= cfg_data;
				REG_PRINT:     print_q     <= cfg_data;
				REG_END:       end_q       <= cfg_data;
				REG_KILL_WORD: kill_word_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// newline reads as space
	assign ch = (in_char == NL_CODE) ? SPACE_CODE : in_char;

	always_comb begin
		priority if (ch == end_q)       cmd = CMD_END;
		else if (ch == erase_q)         cmd = CMD_ERASE;
		else if (ch == kill_line_q)     cmd = CMD_KILL_LINE;
		else if (ch == print_q)         cmd = CMD_PRINT;
		else if (ch == kill_word_q)     cmd = CMD_KILL_WORD;
		else                            cmd = CMD_PLAIN;
	end

endmodule

`default_nettype wire
